// ----- hdl/klt_pkg.sv -----
// Package for the keyword lexer: transfer structs, token codes and character helpers.
// No dependencies; used by the lexer top level and its checker.
package klt_pkg;

    localparam int MAX_WORD_DEF = 32;

    localparam logic [4:0] TYPE_INT32    = 5'd0;
    localparam logic [4:0] TYPE_BOOL     = 5'd1;
    localparam logic [4:0] TYPE_RETURN   = 5'd2;
    localparam logic [4:0] TYPE_PLUS     = 5'd3;
    localparam logic [4:0] TYPE_MINUS    = 5'd4;
    localparam logic [4:0] TYPE_SLASH    = 5'd5;
    localparam logic [4:0] TYPE_ASSIGN   = 5'd6;
    localparam logic [4:0] TYPE_GREATER  = 5'd7;
    localparam logic [4:0] TYPE_LESS     = 5'd8;
    localparam logic [4:0] TYPE_SEMI     = 5'd9;
    localparam logic [4:0] TYPE_COMMA    = 5'd10;
    localparam logic [4:0] TYPE_LPAREN   = 5'd11;
    localparam logic [4:0] TYPE_RPAREN   = 5'd12;
    localparam logic [4:0] TYPE_LBRACE   = 5'd13;
    localparam logic [4:0] TYPE_RBRACE   = 5'd14;
    localparam logic [4:0] TYPE_NUMBER   = 5'd15;
    localparam logic [4:0] TYPE_IDENT    = 5'd16;
    localparam logic [4:0] TYPE_BAD_OP   = 5'd17;
    localparam logic [4:0] TYPE_BAD_CHAR = 5'd18;

    localparam logic [0:0] KIND_TOKEN = 1'b0;
    localparam logic [0:0] KIND_CHAR  = 1'b1;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [47:0] KW_TXT_INT32  = "int32";
    localparam logic [47:0] KW_TXT_BOOL   = "bool";
    localparam logic [47:0] KW_TXT_RETURN = "return";

    typedef enum logic [1:0] {
        CLASS_NONE   = 2'd0,
        CLASS_DIGITS = 2'd1,
        CLASS_IDENT  = 2'd2
    } word_class_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  token_type;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  value_char;
        logic        too_long;
        logic        last;
    } out_item_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        is_punct = ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
                   ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [4:0] punct_type(input logic [7:0] c);
        unique case (c)
            8'h2B:   punct_type = TYPE_PLUS;
            8'h2D:   punct_type = TYPE_MINUS;
            8'h2F:   punct_type = TYPE_SLASH;
            8'h3D:   punct_type = TYPE_ASSIGN;
            8'h3E:   punct_type = TYPE_GREATER;
            8'h3C:   punct_type = TYPE_LESS;
            8'h3B:   punct_type = TYPE_SEMI;
            8'h2C:   punct_type = TYPE_COMMA;
            8'h28:   punct_type = TYPE_LPAREN;
            8'h29:   punct_type = TYPE_RPAREN;
            8'h7B:   punct_type = TYPE_LBRACE;
            8'h7D:   punct_type = TYPE_RBRACE;
            default: punct_type = TYPE_BAD_OP;
        endcase
    endfunction

    // Character p of multi-character keyword k, zero past its end.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [47:0] txt;
        logic [2:0]  n;
        logic [2:0]  pos;
        unique case (k)
            TYPE_INT32[1:0]:  begin txt = KW_TXT_INT32;  n = 3'd5; end
            TYPE_BOOL[1:0]:   begin txt = KW_TXT_BOOL;   n = 3'd4; end
            TYPE_RETURN[1:0]: begin txt = KW_TXT_RETURN; n = 3'd6; end
            default:          begin txt = '0;            n = 3'd0; end
        endcase
        pos = n - 3'd1 - p;
        if (p < n) begin
            kw_char = txt[{pos, 3'b000} +: 8];
        end else begin
            kw_char = 8'h00;
        end
    endfunction

endpackage

// ----- hdl/keyword_lexer_tokenizer.sv -----
// Keyword lexer top level: character stream in, value characters and tokens out.
// Depends on klt_pkg. A character that extends a word is taken in ST_IDLE; any other
// character or an end item passes ST_IDLE, then ST_TOKEN if it ends a keyword, or
// ST_READ and ST_CHAR per value character then ST_TOKEN if it ends a number or
// identifier, then ST_AFTER; an output stall holds each emitting state. Input is taken
// only in ST_IDLE. Reset (aresetn low, synchronous) clears counters, word state, m_valid.
module keyword_lexer_tokenizer #(
    parameter int MAX_WORD = klt_pkg::MAX_WORD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  klt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output klt_pkg::out_item_t m_data
);

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int IDX_W = $clog2(MAX_WORD);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_CHAR  = 5'b00100,
        ST_TOKEN = 5'b01000,
        ST_AFTER = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    klt_pkg::word_class_t class_reg, class_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 ovf_reg, ovf_next;
    logic [2:0]           kw_flags_reg, kw_flags_next;
    logic [15:0]          line_reg, line_next;
    logic [15:0]          col_reg, col_next;
    logic [15:0]          start_col_reg, start_col_next;
    logic [7:0]           pend_ch_reg, pend_ch_next;
    logic                 pend_eot_reg, pend_eot_next;
    logic [4:0]           tok_type_reg, tok_type_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [7:0]           rd_data_reg;
    logic [7:0]           word_mem_reg [MAX_WORD];
    logic                 m_valid_reg;
    klt_pkg::out_item_t   m_data_reg;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [7:0]           wr_data;
    logic                 emit;
    klt_pkg::out_item_t   emit_data;
    logic                 out_free;
    logic                 extend;
    logic                 kw_hit;
    logic [4:0]           kw_type;
    logic                 pend_blank;
    logic                 pend_alnum;
    logic                 pend_emits;
    logic                 short_len;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign extend = !s_data.end_of_text &&
        ((class_reg == klt_pkg::CLASS_DIGITS && klt_pkg::is_digit(s_data.ch)) ||
         (class_reg == klt_pkg::CLASS_IDENT &&
          (klt_pkg::is_alpha(s_data.ch) || klt_pkg::is_digit(s_data.ch))));

    assign short_len = (len_reg[LEN_W-1:3] == '0);

    always_comb begin
        kw_hit  = 1'b1;
        kw_type = klt_pkg::TYPE_INT32;
        if (kw_flags_reg[0] && len_reg == LEN_W'(5)) begin
            kw_type = klt_pkg::TYPE_INT32;
        end else if (kw_flags_reg[1] && len_reg == LEN_W'(4)) begin
            kw_type = klt_pkg::TYPE_BOOL;
        end else if (kw_flags_reg[2] && len_reg == LEN_W'(6)) begin
            kw_type = klt_pkg::TYPE_RETURN;
        end else begin
            kw_hit = 1'b0;
        end
    end

    assign pend_blank = (pend_ch_reg == klt_pkg::CH_NEWLINE) ||
                        (pend_ch_reg == klt_pkg::CH_SPACE) ||
                        (pend_ch_reg == klt_pkg::CH_TAB);
    assign pend_alnum = klt_pkg::is_alpha(pend_ch_reg) || klt_pkg::is_digit(pend_ch_reg);
    assign pend_emits = !pend_eot_reg && !pend_blank && !pend_alnum;

    always_comb begin
        state_next     = state_reg;
        class_next     = class_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        kw_flags_next  = kw_flags_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        start_col_next = start_col_reg;
        pend_ch_next   = pend_ch_reg;
        pend_eot_next  = pend_eot_reg;
        tok_type_next  = tok_type_reg;
        rd_idx_next    = rd_idx_reg;
        wr_en          = 1'b0;
        wr_addr        = len_reg[IDX_W-1:0];
        wr_data        = s_data.ch;
        emit           = 1'b0;
        emit_data      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (extend) begin
                        if (len_reg < LEN_W'(MAX_WORD)) begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                            for (int k = 0; k < 3; k++) begin
                                kw_flags_next[k] = kw_flags_reg[k] && short_len &&
                                    (s_data.ch == klt_pkg::kw_char(2'(k), len_reg[2:0]));
                            end
                        end else begin
                            ovf_next = 1'b1;
                        end
                        col_next = klt_pkg::sat_inc(col_reg);
                    end else begin
                        pend_ch_next  = s_data.ch;
                        pend_eot_next = s_data.end_of_text;
                        if (class_reg != klt_pkg::CLASS_NONE) begin
                            if (kw_hit) begin
                                tok_type_next = kw_type;
                                state_next    = ST_TOKEN;
                            end else begin
                                tok_type_next = (class_reg == klt_pkg::CLASS_DIGITS) ?
                                                klt_pkg::TYPE_NUMBER : klt_pkg::TYPE_IDENT;
                                rd_idx_next   = '0;
                                state_next    = ST_READ;
                            end
                        end else begin
                            state_next = ST_AFTER;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CHAR;
            end
            ST_CHAR: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_data.kind       = klt_pkg::KIND_CHAR;
                    emit_data.token_type = tok_type_reg;
                    emit_data.line       = line_reg;
                    emit_data.column     = start_col_reg;
                    emit_data.value_char = rd_data_reg;
                    emit_data.too_long   = ovf_reg;
                    if (LEN_W'(rd_idx_reg) + LEN_W'(1) == len_reg) begin
                        state_next = ST_TOKEN;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            ST_TOKEN: begin
                if (out_free) begin
                    emit                 = 1'b1;
                    emit_data.kind       = klt_pkg::KIND_TOKEN;
                    emit_data.token_type = tok_type_reg;
                    emit_data.line       = line_reg;
                    emit_data.column     = start_col_reg;
                    emit_data.too_long   = ovf_reg;
                    emit_data.last       = !pend_emits;
                    class_next           = klt_pkg::CLASS_NONE;
                    len_next             = '0;
                    ovf_next             = 1'b0;
                    state_next           = ST_AFTER;
                end
            end
            ST_AFTER: begin
                if (!pend_emits || out_free) begin
                    state_next = ST_IDLE;
                    if (pend_eot_reg) begin
                        line_next      = '0;
                        col_next       = '0;
                        start_col_next = '0;
                    end else if (pend_ch_reg == klt_pkg::CH_NEWLINE) begin
                        line_next = klt_pkg::sat_inc(line_reg);
                        col_next  = '0;
                    end else if (pend_blank) begin
                        col_next = klt_pkg::sat_inc(col_reg);
                    end else if (pend_alnum) begin
                        class_next     = klt_pkg::is_digit(pend_ch_reg) ?
                                         klt_pkg::CLASS_DIGITS : klt_pkg::CLASS_IDENT;
                        len_next       = LEN_W'(1);
                        ovf_next       = 1'b0;
                        start_col_next = col_reg;
                        col_next       = klt_pkg::sat_inc(col_reg);
                        wr_en          = 1'b1;
                        wr_addr        = '0;
                        wr_data        = pend_ch_reg;
                        for (int k = 0; k < 3; k++) begin
                            kw_flags_next[k] = (pend_ch_reg == klt_pkg::kw_char(2'(k), 3'd0));
                        end
                    end else begin
                        emit                 = 1'b1;
                        emit_data.kind       = klt_pkg::KIND_TOKEN;
                        emit_data.token_type = klt_pkg::is_punct(pend_ch_reg) ?
                                               klt_pkg::punct_type(pend_ch_reg) :
                                               klt_pkg::TYPE_BAD_CHAR;
                        emit_data.line       = line_reg;
                        emit_data.column     = col_reg;
                        emit_data.last       = 1'b1;
                        col_next             = klt_pkg::sat_inc(col_reg);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            class_reg     <= klt_pkg::CLASS_NONE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            kw_flags_reg  <= '0;
            line_reg      <= '0;
            col_reg       <= '0;
            start_col_reg <= '0;
            pend_eot_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            class_reg     <= class_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            kw_flags_reg  <= kw_flags_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            start_col_reg <= start_col_next;
            pend_eot_reg  <= pend_eot_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_ch_reg  <= pend_ch_next;
        tok_type_reg <= tok_type_next;
        rd_idx_reg   <= rd_idx_next;
        if (emit) begin
            m_data_reg <= emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            word_mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= word_mem_reg[rd_idx_reg];
    end

endmodule

// ----- hdl/klt_check.sv -----
// Port-level checker for the keyword lexer, bound to the top level below.
// Depends on klt_pkg and keyword_lexer_tokenizer.
module klt_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input klt_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input klt_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    a_char_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind |-> !m_data.last &&
        (m_data.token_type == klt_pkg::TYPE_NUMBER || m_data.token_type == klt_pkg::TYPE_IDENT))
        else $error("value character closes a word or has a non-word type");

    a_token_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.kind |-> m_data.value_char == 8'h00 &&
        m_data.token_type <= klt_pkg::TYPE_BAD_CHAR)
        else $error("token carries a value character or an unknown type");

    a_char_then_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.kind |-> !s_ready)
        else $error("input taken while a word is still draining");

endmodule

bind keyword_lexer_tokenizer klt_check u_klt_check (.*);
